@@ rtl/core/scc_pkg.sv @@
package scc_pkg;

	localparam int STEPS = 100;
	localparam int K_W = (STEPS > 2) ? $clog2(STEPS) : 1;

	// offset = floor((2*d*k + STEPS) / (2*STEPS)), kept as quotient/remainder accumulators
	localparam int DIV_DEN = 2 * STEPS;
	localparam int REM_W = $clog2(DIV_DEN);
	localparam int DVD_W = 27;
	// bias keeps the dividend positive: 2*d >= -2^25 + 2
	localparam int BIAS_E = 26 - REM_W;
	localparam logic [DVD_W-1:0] DIV_BIAS = DVD_W'(DIV_DEN) << BIAS_E;

	// half the biased dividend stays below 2^RCP_IN_W; quotient = (half * RCP_MUL) >> RCP_SH
	localparam int RCP_IN_W = 26;
	localparam int RCP_SH = RCP_IN_W + $clog2(STEPS);
	localparam longint RCP_MUL = ((longint'(1) << RCP_SH) + longint'(STEPS) - 1) / longint'(STEPS);

	localparam int COORD_W = 24;
	localparam int RAD_W = 23;
	localparam int DIFF_W = 25;
	localparam int OFF_W = 27;
	localparam int CODE_W = 19;
	localparam int OP_W = 27;
	localparam int PROD_W = 54;
	localparam int LIM_W = 54;
	localparam int R2_W = 46;
	localparam int SCL_W = 58;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CODE,
		ST_DIVX_GO,
		ST_DIVX_WAIT,
		ST_DIVY_GO,
		ST_DIVY_WAIT,
		ST_SQ_HI,
		ST_SQ_LO,
		ST_SQ_R,
		ST_SQ_END,
		ST_DIFF,
		ST_SQX,
		ST_SQY,
		ST_TEST,
		ST_DONE
	} scc_state_t;

	typedef struct packed {
		logic en;
		logic acc;
	} mul_ctl_t;

	typedef struct packed {
		logic [DVD_W-1:0] quot;
		logic [REM_W-1:0] rem;
	} div_res_t;

endpackage

@@ rtl/core/scc_div.sv @@
module scc_div import scc_pkg::*; (
	input  logic [DVD_W-1:0]  dividend,
	input  logic [PROD_W-1:0] prod,
	output logic [OP_W-1:0]   opnd,
	output div_res_t          res
);

	logic [RCP_IN_W-1:0] half;
	logic [DVD_W-1:0]    quot;
	logic [DVD_W-1:0]    back;

	// dividend is even, so dividend / (2*STEPS) = half / STEPS; the shared
	// multiplier forms half * RCP_MUL and the quotient is its top bits
	assign half = dividend[RCP_IN_W:1];
	assign opnd = OP_W'(half);
	assign quot = DVD_W'(prod[PROD_W-1:RCP_SH]);
	assign back = quot * DVD_W'(STEPS);

	assign res.quot = quot;
	assign res.rem = {half[REM_W-2:0] - back[REM_W-2:0], 1'b0};

endmodule

@@ rtl/core/scc_mul.sv @@
module scc_mul import scc_pkg::*; (
	input  logic              clk,
	input  mul_ctl_t          ctl,
	input  logic [OP_W-1:0]   a,
	input  logic [OP_W-1:0]   b,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;
	logic [2*OP_W-1:0] p;

	assign p = a * b;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= ctl.acc ? prod_q + PROD_W'(p) : PROD_W'(p);
		end
	end

	assign prod = prod_q;

endmodule

@@ rtl/core/segment_circle_contact_search_top.sv @@
// Each item walks n samples, n = 1 to STEPS (100 by default), stopping at the first hit.
// Items are taken only in idle, so a new item waits until the result of the last is registered.
// Setup computes the radius code, two reciprocal multiplies for the per-sample step and
// three squares; each sample then runs DIFF, SQX, SQY and TEST on the one shared multiplier.
// A new item is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) returns to idle with no result pending.
module segment_circle_contact_search_top import scc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic        [RAD_W-1:0]   radius_len,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic signed [COORD_W-1:0] first_x,
	input  logic signed [COORD_W-1:0] first_y,
	input  logic signed [COORD_W-1:0] second_x,
	input  logic signed [COORD_W-1:0] second_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] contact_x,
	output logic signed [COORD_W-1:0] contact_y
);

	scc_state_t state_q, state_d;

	logic        [RAD_W-1:0]   rad_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, sx_q, sy_q;
	logic signed [DIFF_W-1:0]  dx_q, dy_q;
	logic        [CODE_W-1:0]  code_q;
	logic                      code_zero_q;
	logic        [LIM_W-1:0]   hi_q, lo_q;
	logic        [R2_W-1:0]    r2_q;
	logic signed [OFF_W-1:0]   qstepx_q, qstepy_q, offx_q, offy_q;
	logic        [REM_W-1:0]   rstepx_q, rstepy_q, remx_q, remy_q;
	logic        [K_W-1:0]     k_q;
	logic signed [COORD_W-1:0] px_q, py_q, resx_q, resy_q;
	logic        [OP_W-1:0]    ax_q, ay_q;
	logic                      out_valid_q;
	logic signed [COORD_W-1:0] contact_x_q, contact_y_q;

	mul_ctl_t          mctl;
	logic [OP_W-1:0]   ma, mb;
	logic [PROD_W-1:0] prod;
	logic [DVD_W-1:0]  dividend;
	logic [OP_W-1:0]   div_opnd;
	div_res_t          dres;

	logic [DVD_W-1:0]          code_sum;
	logic [CODE_W-1:0]         code_m1;
	logic signed [OFF_W-1:0]   sumx, sumy, qstep;
	logic signed [COORD_W-1:0] pxc, pyc;
	logic signed [DIFF_W-1:0]  ex, ey;
	logic [SCL_W-1:0]          scaled;
	logic                      hit, in_circle, last_k, out_free;
	logic [REM_W:0]            rsumx, rsumy;
	logic                      carryx, carryy;

	scc_mul u_mul (
		.clk (clk),
		.ctl (mctl),
		.a   (ma),
		.b   (mb),
		.prod(prod)
	);

	scc_div u_div (
		.dividend(dividend),
		.prod    (prod),
		.opnd    (div_opnd),
		.res     (dres)
	);

	assign code_sum = (DVD_W'(rad_q) << 3) + (DVD_W'(rad_q) << 1) + DVD_W'(255);
	assign code_m1 = code_q - 1'b1;
	assign qstep = OFF_W'(dres.quot) - (OFF_W'(1) << BIAS_E);

	assign sumx = OFF_W'(sx_q) + offx_q;
	assign sumy = OFF_W'(sy_q) + offy_q;
	assign pxc = sumx[COORD_W-1:0];
	assign pyc = sumy[COORD_W-1:0];
	assign ex = DIFF_W'(pxc) - DIFF_W'(cx_q);
	assign ey = DIFF_W'(pyc) - DIFF_W'(cy_q);

	// 100 * d2 = 64*d2 + 32*d2 + 4*d2
	assign scaled = (SCL_W'(prod) << 6) + (SCL_W'(prod) << 5) + (SCL_W'(prod) << 2);
	assign hit = code_zero_q ? (prod == '0)
	                         : ((scaled > SCL_W'(lo_q)) && (scaled <= SCL_W'(hi_q)));
	assign in_circle = prod < PROD_W'(r2_q);
	assign last_k = k_q == K_W'(STEPS - 1);
	assign out_free = !out_valid_q || out_ready;

	assign rsumx = {1'b0, remx_q} + {1'b0, rstepx_q};
	assign rsumy = {1'b0, remy_q} + {1'b0, rstepy_q};
	assign carryx = rsumx >= (REM_W+1)'(DIV_DEN);
	assign carryy = rsumy >= (REM_W+1)'(DIV_DEN);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_CODE;
			ST_CODE:      state_d = ST_DIVX_GO;
			ST_DIVX_GO:   state_d = ST_DIVX_WAIT;
			ST_DIVX_WAIT: state_d = ST_DIVY_GO;
			ST_DIVY_GO:   state_d = ST_DIVY_WAIT;
			ST_DIVY_WAIT: state_d = ST_SQ_HI;
			ST_SQ_HI:     state_d = ST_SQ_LO;
			ST_SQ_LO:     state_d = ST_SQ_R;
			ST_SQ_R:      state_d = ST_SQ_END;
			ST_SQ_END:    state_d = ST_DIFF;
			ST_DIFF:      state_d = ST_SQX;
			ST_SQX:       state_d = ST_SQY;
			ST_SQY:       state_d = ST_TEST;
			ST_TEST:      state_d = (hit || last_k) ? ST_DONE : ST_DIFF;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mctl = '0;
		ma = '0;
		mb = '0;
		dividend = {dx_q[DIFF_W-1], dx_q, 1'b0} + DIV_BIAS;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DIVX_GO: begin
				mctl.en = 1'b1;
				ma = div_opnd;
				mb = OP_W'(RCP_MUL);
			end
			ST_DIVY_GO: begin
				dividend = {dy_q[DIFF_W-1], dy_q, 1'b0} + DIV_BIAS;
				mctl.en = 1'b1;
				ma = div_opnd;
				mb = OP_W'(RCP_MUL);
			end
			ST_DIVY_WAIT: dividend = {dy_q[DIFF_W-1], dy_q, 1'b0} + DIV_BIAS;
			ST_SQ_HI: begin
				mctl.en = 1'b1;
				ma = OP_W'(code_q);
				mb = OP_W'(code_q);
			end
			ST_SQ_LO: begin
				mctl.en = 1'b1;
				ma = OP_W'(code_m1);
				mb = OP_W'(code_m1);
			end
			ST_SQ_R: begin
				mctl.en = 1'b1;
				ma = OP_W'(rad_q);
				mb = OP_W'(rad_q);
			end
			ST_SQX: begin
				mctl.en = 1'b1;
				ma = ax_q;
				mb = ax_q;
			end
			ST_SQY: begin
				mctl.en = 1'b1;
				mctl.acc = 1'b1;
				ma = ay_q;
				mb = ay_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rad_q <= radius_len;
				cx_q <= center_x;
				cy_q <= center_y;
				sx_q <= second_x;
				sy_q <= second_y;
				dx_q <= DIFF_W'(first_x) - DIFF_W'(second_x);
				dy_q <= DIFF_W'(first_y) - DIFF_W'(second_y);
			end
			ST_CODE: begin
				code_q <= code_sum[DVD_W-1:8];
				code_zero_q <= code_sum[DVD_W-1:8] == '0;
				resx_q <= '0;
				resy_q <= '0;
				k_q <= '0;
				offx_q <= '0;
				offy_q <= '0;
				remx_q <= REM_W'(STEPS);
				remy_q <= REM_W'(STEPS);
			end
			ST_DIVX_WAIT: begin
				qstepx_q <= qstep;
				rstepx_q <= dres.rem;
			end
			ST_DIVY_WAIT: begin
				qstepy_q <= qstep;
				rstepy_q <= dres.rem;
			end
			ST_SQ_LO: hi_q <= LIM_W'(prod) << 16;
			ST_SQ_R: lo_q <= code_zero_q ? '0 : (LIM_W'(prod) << 16);
			ST_SQ_END: r2_q <= prod[R2_W-1:0];
			ST_DIFF: begin
				px_q <= pxc;
				py_q <= pyc;
				ax_q <= ex[DIFF_W-1] ? OP_W'(-ex) : OP_W'(ex);
				ay_q <= ey[DIFF_W-1] ? OP_W'(-ey) : OP_W'(ey);
			end
			ST_TEST: begin
				if (hit || in_circle) begin
					resx_q <= px_q;
					resy_q <= py_q;
				end
				k_q <= k_q + 1'b1;
				offx_q <= offx_q + qstepx_q + OFF_W'(carryx);
				offy_q <= offy_q + qstepy_q + OFF_W'(carryy);
				remx_q <= carryx ? REM_W'(rsumx - (REM_W+1)'(DIV_DEN)) : rsumx[REM_W-1:0];
				remy_q <= carryy ? REM_W'(rsumy - (REM_W+1)'(DIV_DEN)) : rsumy[REM_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					contact_x_q <= resx_q;
					contact_y_q <= resy_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign contact_x = contact_x_q;
	assign contact_y = contact_y_q;

endmodule
